// ===== rtl/hpt_pkg.sv =====
`timescale 1ns / 1ps

package hpt_pkg;

    // divider: quotient bits resolved per pipeline stage
    localparam int DIV_STEP   = 2;
    localparam int NUM_W      = 64;
    localparam int DEN_W      = 31;
    localparam int DIV_STAGES = NUM_W / DIV_STEP;

    typedef enum logic [2:0] {
        CFG_TEMP    = 3'd0,
        CFG_PRESS_A = 3'd1,
        CFG_PRESS_B = 3'd2,
        CFG_MIXED   = 3'd3,
        CFG_HUM     = 3'd4
    } cfg_idx_t;

    // results that ride along the divider
    typedef struct packed {
        logic [17:0] temp_centi;
        logic [16:0] hum;
        logic        div_zero;
        logic        neg;
    } side_t;

endpackage

// ===== rtl/humidity_pressure_temp_compensation_top.sv =====
`timescale 1ns / 1ps
// Path: the front stages, the 64-bit divider pipeline and the back stages lie
// between the accepting edge and the result on the outputs.
// Throughput: one item per cycle; a stalled output freezes the whole pipeline.
// Reset: valid bits clear, all coefficient registers reset to zero (so every
// pressure result then reports a zero divisor).

module humidity_pressure_temp_compensation_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [19:0] raw_temp,
    input  logic [19:0] raw_press,
    input  logic [15:0] raw_hum,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [17:0] temp_centi,
    output logic [24:0] press_q24_8,
    output logic [16:0] hum_q22_10,
    output logic        divisor_zero
);

    function automatic logic [31:0] mul_lo32(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        p = a * b;
        return p[31:0];
    endfunction

    function automatic logic [31:0] asr32(input logic [31:0] x, input int n);
        return 32'($signed(x) >>> n);
    endfunction

    function automatic logic [63:0] asr64(input logic [63:0] x, input int n);
        return 64'($signed(x) >>> n);
    endfunction

    function automatic logic [31:0] sx32(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [63:0] sx64(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    // ---------------- configuration ----------------
    logic [47:0] temp_cf_reg;
    logic [63:0] press_a_reg;
    logic [63:0] press_b_reg;
    logic [47:0] mixed_cf_reg;
    logic [39:0] hum_cf_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            temp_cf_reg  <= '0;
            press_a_reg  <= '0;
            press_b_reg  <= '0;
            mixed_cf_reg <= '0;
            hum_cf_reg   <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                hpt_pkg::CFG_TEMP:    temp_cf_reg  <= cfg_data[47:0];
                hpt_pkg::CFG_PRESS_A: press_a_reg  <= cfg_data;
                hpt_pkg::CFG_PRESS_B: press_b_reg  <= cfg_data;
                hpt_pkg::CFG_MIXED:   mixed_cf_reg <= cfg_data[47:0];
                hpt_pkg::CFG_HUM:     hum_cf_reg   <= cfg_data[39:0];
                default: ;
            endcase
        end
    end

    logic [15:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, h2, h4, h5;
    logic [7:0]  h1, h3, h6;

    assign t1 = temp_cf_reg[15:0];
    assign t2 = temp_cf_reg[31:16];
    assign t3 = temp_cf_reg[47:32];
    assign p1 = press_a_reg[15:0];
    assign p2 = press_a_reg[31:16];
    assign p3 = press_a_reg[47:32];
    assign p4 = press_a_reg[63:48];
    assign p5 = press_b_reg[15:0];
    assign p6 = press_b_reg[31:16];
    assign p7 = press_b_reg[47:32];
    assign p8 = press_b_reg[63:48];
    assign p9 = mixed_cf_reg[15:0];
    assign h1 = mixed_cf_reg[23:16];
    assign h2 = mixed_cf_reg[39:24];
    assign h3 = mixed_cf_reg[47:40];
    assign h4 = hum_cf_reg[15:0];
    assign h5 = hum_cf_reg[31:16];
    assign h6 = hum_cf_reg[39:32];

    // ---------------- pipeline control ----------------
    logic       en;
    logic [9:0] vld_reg;
    logic [5:0] qv_reg;
    logic       div_valid;

    assign en       = !qv_reg[5] || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            qv_reg  <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[8:0], in_valid};
            qv_reg  <= {qv_reg[4:0], div_valid};
        end
    end

    // ---------------- front stages ----------------
    // s0
    logic [19:0] rt0_reg, rp0_reg;
    logic [15:0] rh0_reg;
    // s1
    logic [31:0] ma_reg, mb_reg;
    logic [19:0] rp1_reg;
    logic [15:0] rh1_reg;
    // s2
    logic [31:0] v1_reg, mc_reg;
    logic [19:0] rp2_reg;
    logic [15:0] rh2_reg;
    // s3
    logic [31:0] tf_reg;
    logic [19:0] rp3_reg;
    logic [15:0] rh3_reg;
    // s4
    logic [31:0] tc5_reg, hx5_reg, m1_reg, m2_reg;
    logic [47:0] w1sq_reg;
    logic [39:0] w1p5_s4_reg, w1p2_s4_reg;
    logic [19:0] rp4_reg;
    logic [15:0] rh4_reg;
    // s5
    logic [17:0] tc_s5_reg;
    logic [63:0] a6_reg, a3_reg;
    logic [39:0] w1p5_s5_reg, w1p2_s5_reg;
    logic [19:0] rp5_reg;
    logic [31:0] f1_s5_reg, g0_reg;
    // s6
    logic [17:0] tc_s6_reg;
    logic [63:0] w2_reg, x_reg;
    logic [19:0] rp6_reg;
    logic [31:0] f1_s6_reg, f2p_reg;
    // s7
    logic [17:0] tc_s7_reg;
    logic [47:0] xa_reg;
    logic [31:0] xb_reg, hx_s7_reg;
    logic [63:0] d_reg;
    // s8
    logic [17:0] tc_s8_reg;
    logic [30:0] den_reg;
    logic [63:0] n_reg;
    logic [31:0] xx_reg, hx_s8_reg;
    // s9
    logic [63:0]    magn_reg;
    logic [30:0]    magd_reg;
    hpt_pkg::side_t side_s9_reg;

    logic [31:0] ma_next, mb_next, a1, b1;
    logic [31:0] v1_next, mc_next, tf_next;
    logic [31:0] tc5_next, hx5_next, m1_next, m2_next, hum_x;
    logic [23:0] w1;
    logic [47:0] w1sq_next;
    logic [39:0] w1p5_next, w1p2_next;
    logic [31:0] tcs;
    logic [17:0] tc_next;
    logic [63:0] a6_next, a3_next;
    logic [31:0] f1_next, g0_next;
    logic [63:0] w2_next, x_next;
    logic [31:0] f2p_next;
    logic [20:0] pp;
    logic [47:0] xa_next;
    logic [31:0] xb_next, f2, hx_next;
    logic [63:0] d_next;
    logic [63:0] den_full, n_next;
    logic [31:0] xx_next;
    logic [63:0] magn_next;
    logic [30:0] magd_next;
    logic [31:0] xh, hv, hvc;
    hpt_pkg::side_t side_next;

    always_comb begin
        // temperature
        a1      = {15'b0, rt0_reg[19:3]} - {15'b0, t1, 1'b0};
        b1      = {16'b0, rt0_reg[19:4]} - {16'b0, t1};
        ma_next = mul_lo32(a1, sx32(t2));
        mb_next = mul_lo32(b1, b1);
        v1_next = asr32(ma_reg, 11);
        mc_next = mul_lo32(asr32(mb_reg, 12), sx32(t3));
        tf_next = v1_reg + asr32(mc_reg, 14);

        // s4: fine temperature fans out; |tf| < 2^21 so w1 fits 24 bits
        tc5_next  = mul_lo32(tf_reg, 32'd5);
        w1        = tf_reg[23:0] - 24'd128000;
        w1sq_next = $signed(w1) * $signed(w1);
        w1p5_next = $signed(w1) * $signed(p5);
        w1p2_next = $signed(w1) * $signed(p2);
        hum_x     = tf_reg - 32'd76800;
        hx5_next  = mul_lo32(sx32(h5), hum_x);
        m1_next   = mul_lo32(hum_x, {{24{h6[7]}}, h6});
        m2_next   = mul_lo32(hum_x, {24'b0, h3});

        // s5
        tcs = asr32(tc5_reg + 32'd128, 8);
        if ($signed(tcs) < -32'sd131072)
            tc_next = 18'h20000;
        else if ($signed(tcs) > 32'sd131071)
            tc_next = 18'h1FFFF;
        else
            tc_next = tcs[17:0];
        a6_next = $signed(w1sq_reg) * $signed(p6);
        a3_next = $signed(w1sq_reg) * $signed(p3);
        f1_next = asr32({2'b0, rh4_reg, 14'b0} - {h4[11:0], 20'b0} - hx5_reg + 32'd16384,
                        15);
        g0_next = mul_lo32(asr32(m1_reg, 10), asr32(m2_reg, 11) + 32'd32768);

        // s6
        w2_next  = a6_reg + ({{24{w1p5_s5_reg[39]}}, w1p5_s5_reg} << 17) + (sx64(p4) << 35);
        x_next   = 64'h0000_8000_0000_0000 + asr64(a3_reg, 8)
                 + ({{24{w1p2_s5_reg[39]}}, w1p2_s5_reg} << 12);
        f2p_next = mul_lo32(asr32(g0_reg, 10) + 32'd2097152, sx32(h2));

        // s7: low 64 bits of x * P1 in two partial products
        xa_next = x_reg[31:0] * p1;
        xb_next = mul_lo32(x_reg[63:32], {16'b0, p1});
        pp      = 21'd1048576 - {1'b0, rp6_reg};
        d_next  = {12'b0, pp, 31'b0} - w2_reg;
        f2      = asr32(f2p_reg + 32'd8192, 14);
        hx_next = mul_lo32(f1_s6_reg, f2);

        // s8
        den_full = {16'b0, xa_reg} + {xb_reg, 32'b0};
        n_next   = d_reg * 64'd3125;
        xx_next  = mul_lo32(asr32(hx_s7_reg, 15), asr32(hx_s7_reg, 15));

        // s9: sign-magnitude for the divider, humidity finish
        magn_next = n_reg[63] ? (64'd0 - n_reg) : n_reg;
        magd_next = den_reg[30] ? (31'd0 - den_reg) : den_reg;
        xh  = mul_lo32(asr32(xx_reg, 7), {24'b0, h1});
        hv  = hx_s8_reg - asr32(xh, 4);
        if (hv[31])
            hvc = '0;
        else if (hv > 32'd419430400)
            hvc = 32'd419430400;
        else
            hvc = hv;
        side_next.temp_centi = tc_s8_reg;
        side_next.hum        = hvc[28:12];
        side_next.div_zero   = (den_reg == '0);
        side_next.neg        = n_reg[63] ^ den_reg[30];
    end

    always_ff @(posedge clk) begin
        if (en)
        begin
            rt0_reg     <= raw_temp;
            rp0_reg     <= raw_press;
            rh0_reg     <= raw_hum;

            ma_reg      <= ma_next;
            mb_reg      <= mb_next;
            rp1_reg     <= rp0_reg;
            rh1_reg     <= rh0_reg;

            v1_reg      <= v1_next;
            mc_reg      <= mc_next;
            rp2_reg     <= rp1_reg;
            rh2_reg     <= rh1_reg;

            tf_reg      <= tf_next;
            rp3_reg     <= rp2_reg;
            rh3_reg     <= rh2_reg;

            tc5_reg     <= tc5_next;
            w1sq_reg    <= w1sq_next;
            w1p5_s4_reg <= w1p5_next;
            w1p2_s4_reg <= w1p2_next;
            hx5_reg     <= hx5_next;
            m1_reg      <= m1_next;
            m2_reg      <= m2_next;
            rp4_reg     <= rp3_reg;
            rh4_reg     <= rh3_reg;

            tc_s5_reg   <= tc_next;
            a6_reg      <= a6_next;
            a3_reg      <= a3_next;
            w1p5_s5_reg <= w1p5_s4_reg;
            w1p2_s5_reg <= w1p2_s4_reg;
            rp5_reg     <= rp4_reg;
            f1_s5_reg   <= f1_next;
            g0_reg      <= g0_next;

            tc_s6_reg   <= tc_s5_reg;
            w2_reg      <= w2_next;
            x_reg       <= x_next;
            rp6_reg     <= rp5_reg;
            f1_s6_reg   <= f1_s5_reg;
            f2p_reg     <= f2p_next;

            tc_s7_reg   <= tc_s6_reg;
            xa_reg      <= xa_next;
            xb_reg      <= xb_next;
            d_reg       <= d_next;
            hx_s7_reg   <= hx_next;

            tc_s8_reg   <= tc_s7_reg;
            den_reg     <= den_full[63:33];
            n_reg       <= n_next;
            xx_reg      <= xx_next;
            hx_s8_reg   <= hx_s7_reg;

            magn_reg    <= magn_next;
            magd_reg    <= magd_next;
            side_s9_reg <= side_next;
        end
    end

    // ---------------- divider ----------------
    logic [63:0]    quo;
    hpt_pkg::side_t div_side;

    hpt_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vld_reg[9]),
        .num       (magn_reg),
        .den       (magd_reg),
        .side_in   (side_s9_reg),
        .out_valid (div_valid),
        .quo       (quo),
        .side_out  (div_side)
    );

    // ---------------- back stages ----------------
    hpt_pkg::side_t side_q1_reg, side_q2_reg, side_q3_reg, side_q4_reg, side_q5_reg;
    logic [63:0] p_q1_reg, p_q2_reg, p_q3_reg, p_q4_reg;
    logic [63:0] sq_ll_reg, s_reg, e2raw_q3_reg, e2raw_q4_reg, sum_reg;
    logic [31:0] sq_hl_reg, e2b_reg, e1b_reg;
    logic [48:0] e2a_reg, e1a_reg;
    logic [17:0] temp_centi_reg;
    logic [24:0] press_reg;
    logic [16:0] hum_reg;
    logic        dz_reg;

    logic [63:0] p_next, ps, sq_ll_next, s_next, e2raw_next, e1raw, sum_next, pr;
    logic [31:0] sq_hl_next, e2b_next, e1b_next;
    logic [48:0] e2a_next, e1a_next;
    logic [24:0] press_next;

    always_comb begin
        p_next     = div_side.neg ? (64'd0 - quo) : quo;

        // low 64 bits of ps*ps and P8*p from 32-bit halves
        ps         = asr64(p_q1_reg, 13);
        sq_ll_next = ps[31:0] * ps[31:0];
        sq_hl_next = mul_lo32(ps[63:32], ps[31:0]);
        e2a_next   = $signed({1'b0, p_q1_reg[31:0]}) * $signed(p8);
        e2b_next   = mul_lo32(p_q1_reg[63:32], sx32(p8));

        s_next     = sq_ll_reg + {sq_hl_reg[30:0], 33'b0};
        e2raw_next = {{15{e2a_reg[48]}}, e2a_reg} + {e2b_reg, 32'b0};

        e1a_next   = $signed({1'b0, s_reg[31:0]}) * $signed(p9);
        e1b_next   = mul_lo32(s_reg[63:32], sx32(p9));

        e1raw      = {{15{e1a_reg[48]}}, e1a_reg} + {e1b_reg, 32'b0};
        sum_next   = p_q4_reg + asr64(e1raw, 25) + asr64(e2raw_q4_reg, 19);

        pr = asr64(sum_reg, 8) + (sx64(p7) << 4);
        if (side_q5_reg.div_zero || pr[63])
            press_next = '0;
        else if (pr > 64'd33554431)
            press_next = 25'h1FFFFFF;
        else
            press_next = pr[24:0];
    end

    always_ff @(posedge clk) begin
        if (en)
        begin
            p_q1_reg       <= p_next;
            side_q1_reg    <= div_side;

            sq_ll_reg      <= sq_ll_next;
            sq_hl_reg      <= sq_hl_next;
            e2a_reg        <= e2a_next;
            e2b_reg        <= e2b_next;
            p_q2_reg       <= p_q1_reg;
            side_q2_reg    <= side_q1_reg;

            s_reg          <= s_next;
            e2raw_q3_reg   <= e2raw_next;
            p_q3_reg       <= p_q2_reg;
            side_q3_reg    <= side_q2_reg;

            e1a_reg        <= e1a_next;
            e1b_reg        <= e1b_next;
            e2raw_q4_reg   <= e2raw_q3_reg;
            p_q4_reg       <= p_q3_reg;
            side_q4_reg    <= side_q3_reg;

            sum_reg        <= sum_next;
            side_q5_reg    <= side_q4_reg;

            temp_centi_reg <= side_q5_reg.temp_centi;
            hum_reg        <= side_q5_reg.hum;
            dz_reg         <= side_q5_reg.div_zero;
            press_reg      <= press_next;
        end
    end

    assign out_valid    = qv_reg[5];
    assign temp_centi   = temp_centi_reg;
    assign press_q24_8  = press_reg;
    assign hum_q22_10   = hum_reg;
    assign divisor_zero = dz_reg;

`ifndef NO_ASSERTIONS
    // a frozen pipeline keeps every valid bit
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg) && $stable(qv_reg))
        else $error("valid bits moved while stalled");

    // input back-pressure only comes from a held result
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output stall");

    a_dz: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && divisor_zero |-> press_q24_8 == '0)
        else $error("zero divisor with nonzero pressure");
`endif

endmodule

// ===== rtl/hpt_div.sv =====
`timescale 1ns / 1ps

module hpt_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [hpt_pkg::NUM_W-1:0]     num,
    input  logic [hpt_pkg::DEN_W-1:0]     den,
    input  hpt_pkg::side_t                side_in,
    output logic                          out_valid,
    output logic [hpt_pkg::NUM_W-1:0]     quo,
    output hpt_pkg::side_t                side_out
);

    localparam int NS = hpt_pkg::DIV_STAGES;

    logic [NS-1:0]              vld_reg;
    logic [hpt_pkg::DEN_W-1:0]  rem_reg  [NS];
    logic [hpt_pkg::NUM_W-1:0]  nq_reg   [NS];
    logic [hpt_pkg::DEN_W-1:0]  den_reg  [NS];
    hpt_pkg::side_t             side_reg [NS];
    logic [hpt_pkg::DEN_W-1:0]  rem_next [NS];
    logic [hpt_pkg::NUM_W-1:0]  nq_next  [NS];

    // restoring division; dividend bits shift out the top of nq while
    // quotient bits shift in at the bottom
    always_comb begin
        logic [hpt_pkg::DEN_W-1:0] r;
        logic [hpt_pkg::NUM_W-1:0] x;
        logic [hpt_pkg::DEN_W-1:0] dv;
        logic [hpt_pkg::DEN_W:0]   t;
        for (int i = 0; i < NS; i++) begin
            if (i == 0)
            begin
                r  = '0;
                x  = num;
                dv = den;
            end
            else
            begin
                r  = rem_reg[i-1];
                x  = nq_reg[i-1];
                dv = den_reg[i-1];
            end
            for (int j = 0; j < hpt_pkg::DIV_STEP; j++) begin
                t = {r, x[hpt_pkg::NUM_W-1]};
                x = {x[hpt_pkg::NUM_W-2:0], 1'b0};
                if (t >= {1'b0, dv})
                begin
                    t    = t - {1'b0, dv};
                    x[0] = 1'b1;
                end
                r = t[hpt_pkg::DEN_W-1:0];
            end
            rem_next[i] = r;
            nq_next[i]  = x;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NS-2:0], in_valid};
        end
    end

    always_ff @(posedge clk) begin
        if (en)
        begin
            for (int i = 0; i < NS; i++) begin
                rem_reg[i] <= rem_next[i];
                nq_reg[i]  <= nq_next[i];
                if (i == 0)
                begin
                    den_reg[i]  <= den;
                    side_reg[i] <= side_in;
                end
                else
                begin
                    den_reg[i]  <= den_reg[i-1];
                    side_reg[i] <= side_reg[i-1];
                end
            end
        end
    end

    assign out_valid = vld_reg[NS-1];
    assign quo       = nq_reg[NS-1];
    assign side_out  = side_reg[NS-1];

endmodule
